/* rtl/nptw_pkg.sv */
`timescale 1ns / 1ps

package nptw_pkg;

  localparam int unsigned AddrW      = 52;
  localparam int unsigned GuestAddrW = 48;
  localparam int unsigned EntryW     = 64;
  localparam int unsigned LevelW     = 2;
  localparam int unsigned PermW      = 3;
  localparam int unsigned IdxW       = 9;
  localparam int unsigned LargeBit   = 7;

  localparam logic [AddrW-1:0]  MaskReset = 52'hF_FFFF_FFFF_F000;
  localparam logic [LevelW-1:0] TopLevel  = 2'd3;
  localparam logic [PermW-1:0]  PermAll   = 3'b111;

  localparam logic KindStart = 1'b0;
  localparam logic KindData  = 1'b1;

  localparam logic ResultRequest = 1'b0;
  localparam logic ResultFinish  = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [EntryW-1:0]     root_pointer;
    logic [GuestAddrW-1:0] guest_address;
    logic                  address_space;
    logic [EntryW-1:0]     read_data;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [AddrW-1:0]  read_address;
    logic              read_space;
    logic [EntryW-1:0] final_entry;
    logic [LevelW-1:0] final_level;
  } out_item_t;

endpackage

/* rtl/nested_page_table_walker_unit.sv */
`timescale 1ns / 1ps

// A transaction that is accepted and advances the walk has its result in the output register in the following cycle.
// Throughput: one transaction per cycle while the input is not stalled; the single output register holds the walk step.
// Input stall follows the output register only when it is full and stalled.
// Reset: walk idle, permissions all ones, output empty, frame mask at its default.
module nested_page_table_walker_unit
  import nptw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [AddrW-1:0]    cfg_data_i
);

  logic [AddrW-1:0]      mask_q;
  logic                  busy_q, busy_d;
  logic [LevelW-1:0]     level_q, level_d;
  logic [GuestAddrW-1:0] gaddr_q, gaddr_d;
  logic                  space_q, space_d;
  logic [PermW-1:0]      perm_q, perm_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic                  in_accept;
  logic                  out_accept;
  logic [LevelW-1:0]     idx_level;
  logic [GuestAddrW-1:0] idx_addr;
  logic [IdxW-1:0]       idx;
  logic [AddrW-1:0]      base;
  logic [AddrW-1:0]      entry_addr;
  logic [EntryW-1:0]     entry;
  logic [PermW-1:0]      perm_new;
  logic                  walk_done;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_accept  = out_valid_q & ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign entry     = in_data_i.read_data;
  assign perm_new  = perm_q & entry[PermW-1:0];
  assign walk_done = (entry[PermW-1:0] == '0) | entry[LargeBit] | (level_q == '0);

  always_comb begin
    if (in_data_i.kind == KindStart) begin
      idx_level = TopLevel;
      idx_addr  = in_data_i.guest_address;
      base      = in_data_i.root_pointer[AddrW-1:0];
    end else begin
      idx_level = level_q - 1'b1;
      idx_addr  = gaddr_q;
      base      = entry[AddrW-1:0];
    end
  end

  always_comb begin
    case (idx_level)
      2'd0:    idx = idx_addr[20:12];
      2'd1:    idx = idx_addr[29:21];
      2'd2:    idx = idx_addr[38:30];
      default: idx = idx_addr[47:39];
    endcase
  end

  assign entry_addr = (base & mask_q) | {{(AddrW-IdxW-3){1'b0}}, idx, 3'b000};

  always_comb begin
    busy_d      = busy_q;
    level_d     = level_q;
    gaddr_d     = gaddr_q;
    space_d     = space_q;
    perm_d      = perm_q;
    out_valid_d = out_valid_q & ~out_accept;
    out_d       = out_q;
    if (in_accept) begin
      if (in_data_i.kind == KindStart) begin
        if (!busy_q) begin
          busy_d      = 1'b1;
          level_d     = TopLevel;
          gaddr_d     = in_data_i.guest_address;
          space_d     = in_data_i.address_space;
          perm_d      = PermAll;
          out_valid_d = 1'b1;
          out_d       = '{result_kind:  ResultRequest,
                          read_address: entry_addr,
                          read_space:   in_data_i.address_space,
                          final_entry:  '0,
                          final_level:  '0};
        end
      end else if (busy_q) begin
        perm_d      = perm_new;
        out_valid_d = 1'b1;
        if (walk_done) begin
          busy_d = 1'b0;
          out_d  = '{result_kind:  ResultFinish,
                     read_address: '0,
                     read_space:   1'b0,
                     final_entry:  {entry[EntryW-1:PermW], perm_new},
                     final_level:  level_q};
        end else begin
          level_d = level_q - 1'b1;
          out_d   = '{result_kind:  ResultRequest,
                      read_address: entry_addr,
                      read_space:   space_q,
                      final_entry:  '0,
                      final_level:  '0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= MaskReset;
      busy_q      <= 1'b0;
      level_q     <= '0;
      gaddr_q     <= '0;
      space_q     <= 1'b0;
      perm_q      <= PermAll;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mask_q <= cfg_data_i;
      end
      busy_q      <= busy_d;
      level_q     <= level_d;
      gaddr_q     <= gaddr_d;
      space_q     <= space_d;
      perm_q      <= perm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_start_issues_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.kind == KindStart && !busy_q |=>
      busy_q && out_valid_q && out_q.result_kind == ResultRequest && level_q == TopLevel)
    else $error("start transaction did not open a walk");

  a_last_level_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.kind == KindData && busy_q && level_q == '0 |=>
      !busy_q && out_valid_q && out_q.result_kind == ResultFinish)
    else $error("walk did not finish at the last level");

  a_finish_means_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.result_kind == ResultFinish |-> !busy_q)
    else $error("finish result pending while walk still busy");

  a_request_means_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.result_kind == ResultRequest |-> busy_q)
    else $error("read request pending while walker idle");

  a_idle_data_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_data_i.kind == KindData && !busy_q && !out_accept |=>
      $stable(out_valid_q) && !busy_q)
    else $error("data transaction while idle changed the walker");
`endif

endmodule
